>>> design/cln_pkg.sv
// shared types, constants and the init run table for the char lcd nibble sequencer
// no dependencies
`timescale 1ns / 1ps

package cln_pkg;

  localparam int WaitW = 20;
  localparam int CmdDepthDefault = 2;
  localparam int OutDepthDefault = 2;

  localparam logic [5:0] MAX_SHIFT = 6'd32;
  localparam logic [3:0] INIT_LAST_STEP = 4'd11;

  localparam logic [7:0] BYTE_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] BYTE_SHIFT_RIGHT = 8'h1C;
  localparam logic [7:0] BYTE_CLEAR       = 8'h01;
  localparam logic [7:0] BYTE_HOME        = 8'h02;
  localparam logic [7:0] BYTE_FUNC_SET    = 8'h28;
  localparam logic [7:0] BYTE_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] BYTE_ENTRY_MODE  = 8'h06;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

  localparam logic [WaitW-1:0] RST_SHORT_WAIT  = 20'd40;
  localparam logic [WaitW-1:0] RST_LONG_WAIT   = 20'd1640;
  localparam logic [WaitW-1:0] RST_POWER_WAIT  = 20'd100000;
  localparam logic [WaitW-1:0] RST_FIRST_WAIT  = 20'd10000;
  localparam logic [WaitW-1:0] RST_REPEAT_WAIT = 20'd200;

  typedef enum logic [2:0] {
    OP_DATA        = 3'd0,
    OP_SET_CURSOR  = 3'd1,
    OP_SHIFT_LEFT  = 3'd2,
    OP_SHIFT_RIGHT = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_HOME        = 3'd5,
    OP_INIT        = 3'd6,
    OP_RESET       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CFG_SHORT_WAIT  = 3'd0,
    CFG_LONG_WAIT   = 3'd1,
    CFG_POWER_WAIT  = 3'd2,
    CFG_FIRST_WAIT  = 3'd3,
    CFG_REPEAT_WAIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HOLD_SHORT,
    HOLD_LONG,
    HOLD_FIRST,
    HOLD_REPEAT
  } hold_sel_t;

  typedef struct packed {
    logic             init_run;
    logic             power_up;
    logic             reg_select;
    logic [7:0]       byte_value;
    hold_sel_t        hold_sel;
    logic [5:0]       reps;
  } desc_t;

  typedef struct packed {
    logic             reg_select;
    logic [3:0]       nibble;
    logic [WaitW-1:0] pre_wait;
    logic [WaitW-1:0] hold;
    logic             last;
  } strobe_t;

  typedef struct packed {
    logic [WaitW-1:0] short_wait;
    logic [WaitW-1:0] long_wait;
    logic [WaitW-1:0] power_wait;
    logic [WaitW-1:0] first_wait;
    logic [WaitW-1:0] repeat_wait;
  } cfg_t;

  typedef struct packed {
    logic [3:0] nibble;
    hold_sel_t  hold_sel;
  } init_entry_t;

  function automatic init_entry_t init_entry(input logic [3:0] step);
    init_entry_t e;
    logic [7:0]  b;
    b = 8'h00;
    e.nibble   = NIB_WAKE;
    e.hold_sel = HOLD_SHORT;
    case (step[3:1])
      3'd2:    b = BYTE_FUNC_SET;
      3'd3:    b = BYTE_DISPLAY_ON;
      3'd4:    b = BYTE_CLEAR;
      3'd5:    b = BYTE_ENTRY_MODE;
      default: b = 8'h00;
    endcase
    case (step)
      4'd0:    e.hold_sel = HOLD_FIRST;
      4'd1,
      4'd2:    e.hold_sel = HOLD_REPEAT;
      4'd3:    e.nibble = NIB_FOUR_BIT;
      default: begin
        e.nibble   = step[0] ? b[3:0] : b[7:4];
        e.hold_sel = (b == BYTE_CLEAR) ? HOLD_LONG : HOLD_SHORT;
      end
    endcase
    return e;
  endfunction

endpackage

>>> design/cln_fifo.sv
// small register queue, used between front and back and at the result side
// no dependencies
`timescale 1ns / 1ps

module cln_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/cln_front.sv
// request decoder: turns one lcd request into a strobe run descriptor
// depends on cln_pkg
`timescale 1ns / 1ps

module cln_front (
  input  logic           in_push,
  input  logic [2:0]     in_operation,
  input  logic [7:0]     in_char_value,
  input  logic [5:0]     in_column,
  input  logic           in_row,
  input  logic [5:0]     in_shift_count,
  output logic           in_full,
  input  logic           cmd_full,
  output logic           cmd_push,
  output cln_pkg::desc_t cmd_desc
);

  import cln_pkg::*;

  op_t        op;
  logic       is_shift;
  logic [5:0] shift_reps;

  assign op         = op_t'(in_operation);
  assign is_shift   = (op == OP_SHIFT_LEFT) || (op == OP_SHIFT_RIGHT);
  assign shift_reps = (in_shift_count > MAX_SHIFT) ? MAX_SHIFT : in_shift_count;
  assign in_full    = cmd_full;
  // zero shift count: word is taken but no run is queued
  assign cmd_push   = in_push && !cmd_full && !(is_shift && in_shift_count == 6'd0);

  always_comb begin
    cmd_desc            = '0;
    cmd_desc.reps       = 6'd1;
    cmd_desc.hold_sel   = HOLD_SHORT;
    case (op)
      OP_DATA: begin
        cmd_desc.reg_select = 1'b1;
        cmd_desc.byte_value = in_char_value;
      end
      OP_SET_CURSOR: begin
        cmd_desc.byte_value = {1'b1, in_row, in_column};
      end
      OP_SHIFT_LEFT: begin
        cmd_desc.byte_value = BYTE_SHIFT_LEFT;
        cmd_desc.reps       = shift_reps;
      end
      OP_SHIFT_RIGHT: begin
        cmd_desc.byte_value = BYTE_SHIFT_RIGHT;
        cmd_desc.reps       = shift_reps;
      end
      OP_CLEAR: begin
        cmd_desc.byte_value = BYTE_CLEAR;
        cmd_desc.hold_sel   = HOLD_LONG;
      end
      OP_HOME: begin
        cmd_desc.byte_value = BYTE_HOME;
        cmd_desc.hold_sel   = HOLD_LONG;
      end
      OP_INIT: begin
        cmd_desc.init_run = 1'b1;
        cmd_desc.power_up = 1'b1;
      end
      default: begin
        cmd_desc.init_run = 1'b1;
      end
    endcase
  end

endmodule

>>> design/cln_back.sv
// strobe sequencer: walks a run descriptor, one strobe per cycle unless out_full
// depends on cln_pkg
`timescale 1ns / 1ps

module cln_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cln_pkg::cfg_t    cfg,
  input  logic             cmd_empty,
  input  cln_pkg::desc_t   cmd_desc,
  output logic             cmd_pop,
  input  logic             out_full,
  output logic             out_push,
  output cln_pkg::strobe_t out_strobe
);

  import cln_pkg::*;

  logic        busy_r, busy_nxt;
  desc_t       desc_r, desc_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [5:0]  rep_r, rep_nxt;
  init_entry_t ie;
  hold_sel_t   hsel;

  assign ie = init_entry(step_r);

  always_comb begin
    out_strobe            = '0;
    out_strobe.reg_select = desc_r.reg_select;
    if (desc_r.init_run) begin
      hsel                = ie.hold_sel;
      out_strobe.nibble   = ie.nibble;
      out_strobe.last     = (step_r == INIT_LAST_STEP);
      if (step_r == 4'd0 && desc_r.power_up) begin
        out_strobe.pre_wait = cfg.power_wait;
      end
    end else begin
      hsel                = desc_r.hold_sel;
      out_strobe.nibble   = step_r[0] ? desc_r.byte_value[3:0] : desc_r.byte_value[7:4];
      out_strobe.last     = step_r[0] && (rep_r == 6'd1);
    end
    case (hsel)
      HOLD_SHORT:  out_strobe.hold = cfg.short_wait;
      HOLD_LONG:   out_strobe.hold = cfg.long_wait;
      HOLD_FIRST:  out_strobe.hold = cfg.first_wait;
      HOLD_REPEAT: out_strobe.hold = cfg.repeat_wait;
      default:     out_strobe.hold = cfg.short_wait;
    endcase
  end

  assign out_push = busy_r && !out_full;
  assign cmd_pop  = !busy_r && !cmd_empty;

  always_comb begin
    busy_nxt = busy_r;
    desc_nxt = desc_r;
    step_nxt = step_r;
    rep_nxt  = rep_r;
    if (cmd_pop) begin
      busy_nxt = 1'b1;
      desc_nxt = cmd_desc;
      step_nxt = '0;
      rep_nxt  = cmd_desc.reps;
    end else if (out_push) begin
      if (out_strobe.last) begin
        busy_nxt = 1'b0;
      end else if (desc_r.init_run) begin
        step_nxt = step_r + 4'd1;
      end else if (step_r[0]) begin
        step_nxt = '0;
        rep_nxt  = rep_r - 6'd1;
      end else begin
        step_nxt = 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      rep_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      rep_r  <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

endmodule

>>> design/char_lcd_nibble_sequencer.sv
// top level of the char lcd nibble sequencer: wait registers, decoder, queues, sequencer
// depends on cln_pkg, cln_fifo, cln_front, cln_back
`timescale 1ns / 1ps

// Each request word becomes a run of 4-bit enable strobes for an HD44780-style
// display; one result word per strobe, the final one marked by out_last. A request
// is taken in the cycle it is offered while the request queue has room. The
// sequencer loads a request, then emits one strobe per cycle while the result
// queue has room: data, cursor, clear and home yield 2 strobes, a shift of n
// yields 2n with n capped at 32, and init and reset yield 12. A shift with count
// zero yields no words. The user must write the wait registers through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module char_lcd_nibble_sequencer #(
  parameter int CMD_DEPTH = cln_pkg::CmdDepthDefault,
  parameter int OUT_DEPTH = cln_pkg::OutDepthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [2:0]                in_operation,
  input  logic [7:0]                in_char_value,
  input  logic [5:0]                in_column,
  input  logic                      in_row,
  input  logic [5:0]                in_shift_count,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic                      out_reg_select,
  output logic [3:0]                out_nibble,
  output logic [cln_pkg::WaitW-1:0] out_pre_wait_us,
  output logic [cln_pkg::WaitW-1:0] out_high_time_us,
  output logic [cln_pkg::WaitW-1:0] out_low_time_us,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [cln_pkg::WaitW-1:0] cfg_data
);

  import cln_pkg::*;

  cfg_t    cfg_r;
  desc_t   front_desc, back_desc;
  logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
  strobe_t back_strobe, head_strobe;
  logic    out_push, out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_wait  <= RST_SHORT_WAIT;
      cfg_r.long_wait   <= RST_LONG_WAIT;
      cfg_r.power_wait  <= RST_POWER_WAIT;
      cfg_r.first_wait  <= RST_FIRST_WAIT;
      cfg_r.repeat_wait <= RST_REPEAT_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_WAIT:  cfg_r.short_wait  <= cfg_data;
        CFG_LONG_WAIT:   cfg_r.long_wait   <= cfg_data;
        CFG_POWER_WAIT:  cfg_r.power_wait  <= cfg_data;
        CFG_FIRST_WAIT:  cfg_r.first_wait  <= cfg_data;
        CFG_REPEAT_WAIT: cfg_r.repeat_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  cln_front u_front (
    .in_push        (in_push),
    .in_operation   (in_operation),
    .in_char_value  (in_char_value),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_shift_count (in_shift_count),
    .in_full        (in_full),
    .cmd_full       (cmd_full),
    .cmd_push       (cmd_push),
    .cmd_desc       (front_desc)
  );

  cln_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_desc),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (back_desc),
    .empty   (cmd_empty)
  );

  cln_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_empty  (cmd_empty),
    .cmd_desc   (back_desc),
    .cmd_pop    (cmd_pop),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_strobe (back_strobe)
  );

  cln_fifo #(
    .WIDTH ($bits(strobe_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (back_strobe),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (head_strobe),
    .empty   (out_empty)
  );

  assign out_reg_select   = head_strobe.reg_select;
  assign out_nibble       = head_strobe.nibble;
  assign out_pre_wait_us  = head_strobe.pre_wait;
  assign out_high_time_us = head_strobe.hold;
  assign out_low_time_us  = head_strobe.hold;
  assign out_last         = head_strobe.last;

endmodule

>>> design/cln_checker.sv
// port-level checks for the char lcd nibble sequencer, bound to the top level
// depends on cln_pkg and char_lcd_nibble_sequencer
`timescale 1ns / 1ps

module cln_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_empty,
  input logic                      out_reg_select,
  input logic [3:0]                out_nibble,
  input logic [cln_pkg::WaitW-1:0] out_pre_wait_us,
  input logic [cln_pkg::WaitW-1:0] out_high_time_us,
  input logic [cln_pkg::WaitW-1:0] out_low_time_us,
  input logic                      out_last
);

  import cln_pkg::*;

  // result queue comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // enable is held high and low for the same time
  a_symmetric_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_high_time_us == out_low_time_us))
    else $error("high and low hold differ");

  // data words never carry a power-up wait
  a_data_no_pre_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_reg_select) |-> (out_pre_wait_us == '0))
    else $error("data word with pre wait");

  // a power-up wait only sits on the first wake nibble of an init run
  a_pre_wait_on_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pre_wait_us != '0) |->
      (out_nibble == NIB_WAKE && !out_reg_select && !out_last))
    else $error("pre wait on a word other than the first wake nibble");

endmodule

bind char_lcd_nibble_sequencer cln_checker u_cln_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_reg_select   (out_reg_select),
  .out_nibble       (out_nibble),
  .out_pre_wait_us  (out_pre_wait_us),
  .out_high_time_us (out_high_time_us),
  .out_low_time_us  (out_low_time_us),
  .out_last         (out_last)
);

>>> dv/char_lcd_nibble_sequencer_tb.sv
// self-checking bench for char_lcd_nibble_sequencer: requests go in, strobe words are checked
// against a scoreboard that expands each request into its strobe run
// depends on cln_pkg and the char_lcd_nibble_sequencer rtl
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
  import cln_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          LONG_HOLD      = 400;
  localparam int          SETTLE_CYCLES  = 80;
  localparam int          RANDOM_ITEMS   = 100;
  localparam logic [7:0]  CURSOR_CMD     = 8'h80;
  localparam logic [6:0]  ROW1_OFFSET    = 7'h40;
  localparam logic [2:0]  CFG_NO_REG     = 3'd7;
  localparam logic [19:0] WAIT_MAX       = 20'hFFFFF;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [19:0] pre_wait;
    logic [19:0] high_time;
    logic [19:0] low_time;
    logic        last;
  } strobe_word_t;

  class lcd_scoreboard;
    logic [19:0]  wait_us[5];
    strobe_word_t strobe_q[$];
    int           mismatches;

    function new();
      wait_us[CFG_SHORT_WAIT]  = RST_SHORT_WAIT;
      wait_us[CFG_LONG_WAIT]   = RST_LONG_WAIT;
      wait_us[CFG_POWER_WAIT]  = RST_POWER_WAIT;
      wait_us[CFG_FIRST_WAIT]  = RST_FIRST_WAIT;
      wait_us[CFG_REPEAT_WAIT] = RST_REPEAT_WAIT;
      mismatches = 0;
    endfunction

    function void set_wait(logic [2:0] idx, logic [19:0] value);
      if (idx <= CFG_REPEAT_WAIT) wait_us[idx] = value;
    endfunction

    function void add_strobe(logic rs, logic [3:0] nib, logic [19:0] pre, logic [19:0] hold);
      strobe_word_t w;
      w.reg_select = rs;
      w.nibble     = nib;
      w.pre_wait   = pre;
      w.high_time  = hold;
      w.low_time   = hold;
      w.last       = 1'b0;
      strobe_q.push_back(w);
    endfunction

    function void add_byte(logic rs, logic [7:0] b, logic [19:0] hold);
      add_strobe(rs, b[7:4], '0, hold);
      add_strobe(rs, b[3:0], '0, hold);
    endfunction

    // expands one request into its strobe run
    function void note_request(logic [2:0] op, logic [7:0] ch, logic [5:0] col, logic row,
                               logic [5:0] cnt);
      int         start_size;
      logic [6:0] addr;
      logic [5:0] reps;
      start_size = strobe_q.size();
      case (op_t'(op))
        OP_DATA: add_byte(1'b1, ch, wait_us[CFG_SHORT_WAIT]);
        OP_SET_CURSOR: begin
          addr = 7'(col) + (row ? ROW1_OFFSET : 7'd0);
          add_byte(1'b0, CURSOR_CMD | {1'b0, addr}, wait_us[CFG_SHORT_WAIT]);
        end
        OP_SHIFT_LEFT, OP_SHIFT_RIGHT: begin
          reps = (cnt > MAX_SHIFT) ? MAX_SHIFT : cnt;
          for (int i = 0; i < int'(reps); i++)
            add_byte(1'b0, (op_t'(op) == OP_SHIFT_LEFT) ? BYTE_SHIFT_LEFT : BYTE_SHIFT_RIGHT,
                     wait_us[CFG_SHORT_WAIT]);
        end
        OP_CLEAR: add_byte(1'b0, BYTE_CLEAR, wait_us[CFG_LONG_WAIT]);
        OP_HOME: add_byte(1'b0, BYTE_HOME, wait_us[CFG_LONG_WAIT]);
        default: begin
          add_strobe(1'b0, NIB_WAKE, (op_t'(op) == OP_INIT) ? wait_us[CFG_POWER_WAIT] : '0,
                     wait_us[CFG_FIRST_WAIT]);
          add_strobe(1'b0, NIB_WAKE, '0, wait_us[CFG_REPEAT_WAIT]);
          add_strobe(1'b0, NIB_WAKE, '0, wait_us[CFG_REPEAT_WAIT]);
          add_strobe(1'b0, NIB_FOUR_BIT, '0, wait_us[CFG_SHORT_WAIT]);
          add_byte(1'b0, BYTE_FUNC_SET, wait_us[CFG_SHORT_WAIT]);
          add_byte(1'b0, BYTE_DISPLAY_ON, wait_us[CFG_SHORT_WAIT]);
          add_byte(1'b0, BYTE_CLEAR, wait_us[CFG_LONG_WAIT]);
          add_byte(1'b0, BYTE_ENTRY_MODE, wait_us[CFG_SHORT_WAIT]);
        end
      endcase
      if (strobe_q.size() > start_size) strobe_q[strobe_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_word(strobe_word_t got);
      strobe_word_t exp;
      if (strobe_q.size() == 0) begin
        report($sformatf("unexpected word rs=%0d nib=%h pre=%0d hi=%0d lo=%0d last=%0d",
                         got.reg_select, got.nibble, got.pre_wait, got.high_time,
                         got.low_time, got.last));
        return;
      end
      exp = strobe_q.pop_front();
      if (got.reg_select !== exp.reg_select || got.nibble !== exp.nibble ||
          got.pre_wait !== exp.pre_wait || got.high_time !== exp.high_time ||
          got.low_time !== exp.low_time || got.last !== exp.last)
        report($sformatf({"word mismatch exp rs=%0d nib=%h pre=%0d hi=%0d lo=%0d last=%0d",
                          " got rs=%0d nib=%h pre=%0d hi=%0d lo=%0d last=%0d"},
                         exp.reg_select, exp.nibble, exp.pre_wait, exp.high_time,
                         exp.low_time, exp.last, got.reg_select, got.nibble, got.pre_wait,
                         got.high_time, got.low_time, got.last));
    endfunction

    function int pending();
      return strobe_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [2:0]  in_operation;
  logic [7:0]  in_char_value;
  logic [5:0]  in_column;
  logic        in_row;
  logic [5:0]  in_shift_count;
  logic        out_empty;
  logic        out_pop;
  logic        out_reg_select;
  logic [3:0]  out_nibble;
  logic [19:0] out_pre_wait_us;
  logic [19:0] out_high_time_us;
  logic [19:0] out_low_time_us;
  logic        out_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  lcd_scoreboard sb;
  int            send_idle;
  int            recv_idle;
  bit            hold_pop_req;
  int            quiet_cycles;

  char_lcd_nibble_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_char_value    (in_char_value),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_shift_count   (in_shift_count),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_reg_select   (out_reg_select),
    .out_nibble       (out_nibble),
    .out_pre_wait_us  (out_pre_wait_us),
    .out_high_time_us (out_high_time_us),
    .out_low_time_us  (out_low_time_us),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_request(in_operation, in_char_value, in_column, in_row, in_shift_count);
      end
      if (out_pop && !out_empty) begin
        sb.check_word({out_reg_select, out_nibble, out_pre_wait_us, out_high_time_us,
                       out_low_time_us, out_last});
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_pop_req) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_pop_req = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic push_request(input logic [2:0] op, input logic [7:0] ch, input logic [5:0] col,
                              input logic row, input logic [5:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_operation   <= op;
    in_char_value  <= ch;
    in_column      <= col;
    in_row         <= row;
    in_shift_count <= cnt;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic push_random();
    int          pick;
    logic [2:0]  op;
    logic [5:0]  cnt;
    pick = $urandom_range(99);
    if (pick < 30) op = OP_DATA;
    else if (pick < 50) op = OP_SET_CURSOR;
    else if (pick < 58) op = OP_SHIFT_LEFT;
    else if (pick < 66) op = OP_SHIFT_RIGHT;
    else if (pick < 73) op = OP_CLEAR;
    else if (pick < 80) op = OP_HOME;
    else if (pick < 85) op = OP_INIT;
    else if (pick < 90) op = OP_RESET;
    else op = 3'($urandom_range(7));
    cnt = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4));
    push_request(op, 8'($urandom_range(255)), 6'($urandom_range(63)), 1'($urandom_range(1)),
                 cnt);
  endtask

  task automatic write_wait(input logic [2:0] idx, input logic [19:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_wait(idx, value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_operation   = OP_DATA;
    in_char_value  = '0;
    in_column      = '0;
    in_row         = 1'b0;
    in_shift_count = '0;
    out_pop        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SHORT_WAIT;
    cfg_data       = '0;
    send_idle      = 0;
    recv_idle      = 0;
    hold_pop_req   = 1'b0;
    quiet_cycles   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at reset waits
    push_request(OP_DATA, 8'h00, 6'd0, 1'b0, 6'd0);
    push_request(OP_DATA, 8'hFF, 6'd63, 1'b1, 6'd63);
    push_request(OP_DATA, 8'hA5, 6'd21, 1'b0, 6'd5);
    push_request(OP_SET_CURSOR, 8'h00, 6'd0, 1'b0, 6'd0);
    push_request(OP_SET_CURSOR, 8'hFF, 6'd39, 1'b1, 6'd63);
    push_request(OP_SET_CURSOR, 8'h5A, 6'd40, 1'b0, 6'd1);
    push_request(OP_SET_CURSOR, 8'h00, 6'd63, 1'b1, 6'd0);
    push_request(OP_SHIFT_LEFT, 8'h00, 6'd0, 1'b0, 6'd0);
    push_request(OP_SHIFT_RIGHT, 8'hFF, 6'd63, 1'b1, 6'd0);
    push_request(OP_SHIFT_LEFT, 8'h00, 6'd0, 1'b0, 6'd1);
    push_request(OP_SHIFT_RIGHT, 8'h00, 6'd0, 1'b0, 6'd32);
    push_request(OP_SHIFT_LEFT, 8'h00, 6'd0, 1'b0, 6'd33);
    push_request(OP_SHIFT_RIGHT, 8'h00, 6'd0, 1'b0, 6'd63);
    push_request(OP_CLEAR, 8'hFF, 6'd63, 1'b1, 6'd63);
    push_request(OP_HOME, 8'h00, 6'd0, 1'b0, 6'd0);
    push_request(OP_INIT, 8'h00, 6'd0, 1'b0, 6'd0);
    push_request(OP_RESET, 8'hFF, 6'd63, 1'b1, 6'd63);
    push_request(OP_DATA, 8'h41, 6'd0, 1'b0, 6'd0);
    wait_idle();

    // smallest waits, sender 25 / receiver 80
    write_wait(CFG_SHORT_WAIT, 20'd1);
    write_wait(CFG_LONG_WAIT, 20'd1);
    write_wait(CFG_POWER_WAIT, 20'd0);
    write_wait(CFG_FIRST_WAIT, 20'd1);
    write_wait(CFG_REPEAT_WAIT, 20'd1);
    write_wait(CFG_NO_REG, 20'($urandom_range(20'hFFFFF)));
    push_request(OP_INIT, 8'h00, 6'd0, 1'b0, 6'd0);
    send_idle = 25;
    recv_idle = 80;
    repeat (RANDOM_ITEMS) push_random();
    wait_idle();

    // largest waits, sender 80 / receiver 25
    write_wait(CFG_SHORT_WAIT, WAIT_MAX);
    write_wait(CFG_LONG_WAIT, WAIT_MAX);
    write_wait(CFG_POWER_WAIT, WAIT_MAX);
    write_wait(CFG_FIRST_WAIT, WAIT_MAX);
    write_wait(CFG_REPEAT_WAIT, WAIT_MAX);
    push_request(OP_INIT, 8'h00, 6'd0, 1'b0, 6'd0);
    send_idle = 80;
    recv_idle = 25;
    repeat (RANDOM_ITEMS) push_random();
    wait_idle();

    // random waits, no idling, long receiver stall up front
    write_wait(CFG_SHORT_WAIT, 20'($urandom_range(20'hFFFFF, 1)));
    write_wait(CFG_LONG_WAIT, 20'($urandom_range(20'hFFFFF, 1)));
    write_wait(CFG_POWER_WAIT, 20'($urandom_range(20'hFFFFF)));
    write_wait(CFG_FIRST_WAIT, 20'($urandom_range(20'hFFFFF, 1)));
    write_wait(CFG_REPEAT_WAIT, 20'($urandom_range(20'hFFFFF, 1)));
    send_idle = 0;
    recv_idle = 0;
    hold_pop_req = 1'b1;
    repeat (12) push_request(OP_DATA, 8'($urandom_range(255)), 6'($urandom_range(63)),
                             1'($urandom_range(1)), 6'($urandom_range(63)));
    repeat (RANDOM_ITEMS) push_random();
    wait_idle();

    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
